// ===== src/per_cpu_page_free_list_allocator_top_assert.svh =====
// Assertion macros for the page allocator.
// Each check is clocked on clk and disabled while rstn is low.
`ifndef PER_CPU_PAGE_FREE_LIST_ALLOCATOR_TOP_ASSERT_SVH
`define PER_CPU_PAGE_FREE_LIST_ALLOCATOR_TOP_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication.
`define PPFL_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PPFL_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PPFL_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg)
`define PPFL_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ===== src/ppfl_pkg.sv =====
`timescale 1ns / 1ps

package ppfl_pkg;

    localparam int ADDR_W    = 32;
    localparam int CPU_W     = 3;
    localparam int ACT_W     = 1;
    localparam int STAT_W    = 2;
    localparam int CFG_IDX_W = 1;

    localparam int NUM_CPUS_DEF   = 8;
    localparam int NUM_PAGES_DEF  = 4096;
    localparam int PAGE_BYTES_DEF = 4096;

    localparam logic [ACT_W-1:0] ACT_ALLOC = 1'b0;
    localparam logic [ACT_W-1:0] ACT_FREE  = 1'b1;

    localparam logic [STAT_W-1:0] ST_ALLOC = 2'd0;
    localparam logic [STAT_W-1:0] ST_OOM   = 2'd1;
    localparam logic [STAT_W-1:0] ST_FREED = 2'd2;
    localparam logic [STAT_W-1:0] ST_BAD   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_LOW = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TOP = 1'b1;

    localparam logic [ADDR_W-1:0] LOW_RST = 32'h0000_0000;
    localparam logic [ADDR_W-1:0] TOP_RST = 32'h8800_0000;

endpackage

// ===== src/ppfl_req_if.sv =====
`timescale 1ns / 1ps

interface ppfl_req_if;
    logic                         valid;
    logic                         ready;
    logic [ppfl_pkg::ACT_W-1:0]   action;
    logic [ppfl_pkg::CPU_W-1:0]   cpu;
    logic [ppfl_pkg::ADDR_W-1:0]  address;

    modport source (output valid, output action, output cpu, output address, input ready);
    modport sink   (input valid, input action, input cpu, input address, output ready);
endinterface

// ===== src/ppfl_rsp_if.sv =====
`timescale 1ns / 1ps

interface ppfl_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [ppfl_pkg::ADDR_W-1:0]  page_address;
    logic [ppfl_pkg::STAT_W-1:0]  status;

    modport source (output valid, output page_address, output status, input ready);
    modport sink   (input valid, input page_address, input status, output ready);
endinterface

// ===== src/ppfl_ram.sv =====
`timescale 1ns / 1ps

module ppfl_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/ppfl_free_chk.sv =====
`timescale 1ns / 1ps

module ppfl_free_chk #(
    parameter int NUM_PAGES  = ppfl_pkg::NUM_PAGES_DEF,
    parameter int PAGE_BYTES = ppfl_pkg::PAGE_BYTES_DEF
) (
    input  logic [ppfl_pkg::ADDR_W-1:0] i_address,
    input  logic [ppfl_pkg::ADDR_W-1:0] i_low,
    input  logic [ppfl_pkg::ADDR_W-1:0] i_top,
    input  logic [ppfl_pkg::ADDR_W:0]   i_base,
    input  logic [ppfl_pkg::ADDR_W+1:0] i_lim,
    output logic                        o_bad,
    output logic [$clog2(NUM_PAGES)-1:0] o_idx
);

    localparam int PW  = $clog2(NUM_PAGES);
    localparam int PBL = $clog2(PAGE_BYTES);
    localparam int BW  = ppfl_pkg::ADDR_W + 1;

    logic [BW-1:0] w_diff;

    // lim is base plus the span of the store, so the page number check is one compare
    assign o_bad = (i_address[PBL-1:0] != '0)
                || (i_address < i_low)
                || (i_address >= i_top)
                || ({1'b0, i_address} < i_base)
                || ({2'b00, i_address} >= i_lim);

    assign w_diff = {1'b0, i_address} - i_base;
    assign o_idx  = w_diff[PBL +: PW];

endmodule

// ===== src/per_cpu_page_free_list_allocator_top.sv =====
// Result: registered when the item completes execution, which waits while the previous result is not yet taken.
// A new item is taken only once the previous one has completed; the link memory is read in the accept
// cycle and the list head is updated from its data when execution completes.
// Reset: all lists empty, low_address 0, top_address 0x88000000.
// The link memory is not cleared; a link is written whenever its page is freed.
`timescale 1ns / 1ps
`include "per_cpu_page_free_list_allocator_top_assert.svh"

module per_cpu_page_free_list_allocator_top #(
    parameter int NUM_CPUS   = ppfl_pkg::NUM_CPUS_DEF,
    parameter int NUM_PAGES  = ppfl_pkg::NUM_PAGES_DEF,
    parameter int PAGE_BYTES = ppfl_pkg::PAGE_BYTES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ppfl_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ppfl_pkg::ADDR_W-1:0]    i_cfg_data,
    ppfl_req_if.sink                       i_req,
    ppfl_rsp_if.source                     o_rsp
);

    localparam int AW   = ppfl_pkg::ADDR_W;
    localparam int BW   = AW + 1;
    localparam int LIMW = AW + 2;
    localparam int PW   = $clog2(NUM_PAGES);
    localparam int LW   = PW + 1;
    localparam int PBL  = $clog2(PAGE_BYTES);
    localparam int CIW  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam longint SPAN = longint'(NUM_PAGES) * longint'(PAGE_BYTES);
    localparam logic [BW-1:0]   PB_MASK = BW'(PAGE_BYTES - 1);
    localparam logic [LIMW-1:0] SPAN_L  = LIMW'(SPAN);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    // configuration
    logic [AW-1:0]   r_low;
    logic [AW-1:0]   r_top;
    logic [BW-1:0]   r_base;
    logic [LIMW-1:0] r_lim;
    logic [BW-1:0]   n_base;
    logic [LIMW-1:0] n_lim;

    // list heads
    logic [PW-1:0]       r_head_page [NUM_CPUS];
    logic [NUM_CPUS-1:0] r_head_valid;

    // item in flight
    logic                       r_state;
    logic                       n_state;
    logic [ppfl_pkg::ACT_W-1:0] r_action;
    logic [CIW-1:0]             r_cidx;
    logic                       r_hit;
    logic [PW-1:0]              r_page;
    logic [AW-1:0]              r_addr;

    // result register
    logic                        r_o_valid;
    logic [AW-1:0]               r_o_page_address;
    logic [ppfl_pkg::STAT_W-1:0] r_o_status;

    logic           w_in_acc;
    logic           w_out_free;
    logic           w_done;
    logic [CIW-1:0] w_cpu_m;
    logic [CIW-1:0] w_vic;
    logic           w_vic_hit;
    logic [CIW-1:0] w_hsel;
    logic [PW-1:0]  w_head_rd;
    logic           w_bad;
    logic [PW-1:0]  w_idx;
    logic           w_ram_we;
    logic [LW-1:0]  w_ram_wdata;
    logic           w_ram_re;
    logic [LW-1:0]  w_link;
    logic           w_link_end;
    logic [AW-1:0]  w_alloc_addr;

    assign n_base = ({1'b0, i_cfg_data} + PB_MASK) & ~PB_MASK;
    assign n_lim  = {1'b0, n_base} + SPAN_L;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low  <= ppfl_pkg::LOW_RST;
            r_top  <= ppfl_pkg::TOP_RST;
            r_base <= '0;
            r_lim  <= SPAN_L;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    ppfl_pkg::REG_LOW: begin
                        r_low  <= i_cfg_data;
                        r_base <= n_base;
                        r_lim  <= n_lim;
                    end
                    ppfl_pkg::REG_TOP: begin
                        r_top <= i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // cpu field modulo NUM_CPUS
    always_comb begin
        logic [ppfl_pkg::CPU_W:0] t;
        t = {1'b0, i_req.cpu};
        for (int k = 0; k < 8; k++) begin
            if (t >= (ppfl_pkg::CPU_W+1)'(NUM_CPUS)) begin
                t = t - (ppfl_pkg::CPU_W+1)'(NUM_CPUS);
            end
        end
        w_cpu_m = CIW'(t);
    end

    // first non-empty list in rotating order cpu, cpu+1, ...
    always_comb begin
        logic [CIW:0] s;
        w_vic     = '0;
        w_vic_hit = 1'b0;
        for (int i = NUM_CPUS - 1; i >= 0; i--) begin
            s = {1'b0, w_cpu_m} + (CIW+1)'(i);
            if (s >= (CIW+1)'(NUM_CPUS)) begin
                s = s - (CIW+1)'(NUM_CPUS);
            end
            if (r_head_valid[CIW'(s)]) begin
                w_vic     = CIW'(s);
                w_vic_hit = 1'b1;
            end
        end
    end

    assign w_in_acc    = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign w_out_free  = !r_o_valid || o_rsp.ready;
    assign w_done      = (r_state == S_EXEC) && w_out_free;

    assign w_hsel    = (r_state == S_IDLE) ? w_vic : r_cidx;
    assign w_head_rd = r_head_page[w_hsel];

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_action <= i_req.action;
            r_cidx   <= (i_req.action == ppfl_pkg::ACT_FREE) ? w_cpu_m : w_vic;
            r_hit    <= w_vic_hit;
            r_page   <= w_head_rd;
            r_addr   <= i_req.address;
        end
    end

    ppfl_free_chk #(
        .NUM_PAGES  (NUM_PAGES),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_free_chk (
        .i_address (r_addr),
        .i_low     (r_low),
        .i_top     (r_top),
        .i_base    (r_base),
        .i_lim     (r_lim),
        .o_bad     (w_bad),
        .o_idx     (w_idx)
    );

    // read the popped page's link while the item is accepted
    assign w_ram_re    = w_in_acc && (i_req.action == ppfl_pkg::ACT_ALLOC) && w_vic_hit;
    assign w_ram_we    = w_done && (r_action == ppfl_pkg::ACT_FREE) && !w_bad;
    assign w_ram_wdata = r_head_valid[r_cidx] ? ({1'b0, w_head_rd} + LW'(1)) : '0;

    ppfl_ram #(
        .WIDTH (LW),
        .DEPTH (NUM_PAGES)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_idx),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_head_rd),
        .o_rdata (w_link)
    );

    assign w_link_end = (w_link == '0) || (w_link > LW'(NUM_PAGES));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_valid <= '0;
            for (int c = 0; c < NUM_CPUS; c++) begin
                r_head_page[c] <= '0;
            end
        end else if (w_done) begin
            if (r_action == ppfl_pkg::ACT_FREE) begin
                if (!w_bad) begin
                    r_head_page[r_cidx]  <= w_idx;
                    r_head_valid[r_cidx] <= 1'b1;
                end
            end else if (r_hit) begin
                if (w_link_end) begin
                    r_head_page[r_cidx]  <= '0;
                    r_head_valid[r_cidx] <= 1'b0;
                end else begin
                    r_head_page[r_cidx] <= PW'(w_link - LW'(1));
                end
            end
        end
    end

    assign w_alloc_addr = AW'(r_base + (BW'(r_page) << PBL));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_done) begin
            r_o_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            if (r_action == ppfl_pkg::ACT_FREE) begin
                r_o_page_address <= '0;
                r_o_status       <= w_bad ? ppfl_pkg::ST_BAD : ppfl_pkg::ST_FREED;
            end else if (r_hit) begin
                r_o_page_address <= w_alloc_addr;
                r_o_status       <= ppfl_pkg::ST_ALLOC;
            end else begin
                r_o_page_address <= '0;
                r_o_status       <= ppfl_pkg::ST_OOM;
            end
        end
    end

    assign o_rsp.valid        = r_o_valid;
    assign o_rsp.page_address = r_o_page_address;
    assign o_rsp.status       = r_o_status;

    `PPFL_ASSERT_NXT(a_acc_exec, i_clk, i_rst_n, w_in_acc, r_state == S_EXEC, "accepted item did not enter execution")
    `PPFL_ASSERT_NXT(a_idle_heads, i_clk, i_rst_n, r_state == S_IDLE, $stable(r_head_valid), "list heads changed while idle")
    `PPFL_ASSERT_NOW(a_we_free, i_clk, i_rst_n, w_ram_we, (r_state == S_EXEC) && (r_action == ppfl_pkg::ACT_FREE), "link written outside a free")
    `PPFL_ASSERT_NOW(a_zero_addr, i_clk, i_rst_n, o_rsp.valid && (o_rsp.status != ppfl_pkg::ST_ALLOC), o_rsp.page_address == '0, "nonzero address without allocation")

endmodule
